### rtl/imucaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imucaf_pkg
// Shared widths, constants, sequencer states and the CORDIC angle table.
// ----------------------------------------------------------------------------
package imucaf_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int TABLE_FRAC  = 24;
	localparam int RND_SH      = TABLE_FRAC - FRAC_BITS;
	localparam int CORDIC_LAST = 25;

	localparam int S_TDATA_W   = 120;
	localparam int M_TDATA_W   = 160;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 27;

	// raw / 32.8 == raw * 5 / 164
	localparam int RATE_MUL    = 5;
	localparam int DIV_RATE    = 164;
	localparam int DIV_TIME    = 1000000;
	localparam int DIV_MIX     = 20;
	localparam int MIX_OLD     = 19;
	localparam int DT_MAX      = 1000000;

	// each divisor = 2^SH * odd part; the odd part is handled by reciprocal
	// multiply on 14-bit quotient digits, three digits per job
	localparam int RATE_SH     = 2;
	localparam int TIME_SH     = 6;
	localparam int MIX_SH      = 2;
	localparam int RATE_DSR    = DIV_RATE >> RATE_SH;
	localparam int TIME_DSR    = DIV_TIME >> TIME_SH;
	localparam int MIX_DSR     = DIV_MIX >> MIX_SH;
	localparam int DIG_W       = 14;
	localparam int DIV_DIGITS  = 3;
	localparam int NUM_W       = DIG_W * DIV_DIGITS;
	localparam int DSR_W       = 14;
	localparam int RCP_W       = 26;
	localparam int RCP_SH      = 28;
	localparam int RATE_RCP    = (1 << RCP_SH) / RATE_DSR;
	localparam int TIME_RCP    = (1 << RCP_SH) / TIME_DSR;
	localparam int MIX_RCP     = (1 << RCP_SH) / MIX_DSR;

	localparam int RATE_MAX    = 134217727;
	localparam int RATE_MIN    = -134217728;
	localparam int HALF_TURN   = 180 << FRAC_BITS;
	localparam int FULL_TURN   = 360 << FRAC_BITS;
	localparam int ANGLE_LIM   = (HALF_TURN > 16777215) ? 16777215 : HALF_TURN;

	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS_P   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS_R   = 3'd4;

	// job numbers of the shared divider
	localparam logic [2:0] JOB_RATE_X = 3'd0;
	localparam logic [2:0] JOB_RATE_Y = 3'd1;
	localparam logic [2:0] JOB_RATE_Z = 3'd2;
	localparam logic [2:0] JOB_INC_X  = 3'd3;
	localparam logic [2:0] JOB_INC_Y  = 3'd4;
	localparam logic [2:0] JOB_INC_Z  = 3'd5;
	localparam logic [2:0] JOB_MIX_P  = 3'd6;
	localparam logic [2:0] JOB_MIX_R  = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIVM,
		ST_DIV,
		ST_WB,
		ST_TSUM,
		ST_SQRT,
		ST_CINIT,
		ST_CORDIC,
		ST_TWB,
		ST_YAW,
		ST_DONE
	} state_t;

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0:  v = 32'sd754974720;
			5'd1:  v = 32'sd445687602;
			5'd2:  v = 32'sd235489088;
			5'd3:  v = 32'sd119537938;
			5'd4:  v = 32'sd60000934;
			5'd5:  v = 32'sd30029717;
			5'd6:  v = 32'sd15018523;
			5'd7:  v = 32'sd7509720;
			5'd8:  v = 32'sd3754917;
			5'd9:  v = 32'sd1877466;
			5'd10: v = 32'sd938734;
			5'd11: v = 32'sd469367;
			5'd12: v = 32'sd234684;
			5'd13: v = 32'sd117342;
			5'd14: v = 32'sd58671;
			5'd15: v = 32'sd29335;
			5'd16: v = 32'sd14668;
			5'd17: v = 32'sd7334;
			5'd18: v = 32'sd3667;
			5'd19: v = 32'sd1833;
			5'd20: v = 32'sd917;
			5'd21: v = 32'sd458;
			5'd22: v = 32'sd229;
			5'd23: v = 32'sd115;
			5'd24: v = 32'sd57;
			5'd25: v = 32'sd29;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/imu_complementary_attitude_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top
// Complementary-filter attitude estimator, one IMU sample per transfer.
//
// s_tdata (one sample) in, m_tdata (pitch/roll/yaw and three rates) out,
// both with tvalid/tready. cfg_we/cfg_index/cfg_data write the bias
// registers; write them only while the block is idle.
// Each sample, from its transfer to a valid result, runs through eight
// divide-by-constant jobs (setup, load, three 14-bit quotient digits by
// reciprocal multiply and correction, write back), plus two tilt angles
// (a 24-step square root and a 26-step CORDIC on one shift-add unit),
// then yaw and output load.
// s_tready is high only while the sequencer is idle; one sample is worked
// on at a time, so a new sample is taken only once the last is through. The
// result sits in an output register, so a new sample is taken while the
// previous result waits; if it is still not taken when the next one is
// done, the sequencer holds until the output frees up.
// Reset clears the angles, the biases and the output valid flag.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_raw_x, accel_raw_y,
	// accel_raw_z, elapsed_us, zero pad
	input  wire logic [imucaf_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// pitch_deg, roll_deg, yaw_deg, pitch_rate, roll_rate, yaw_rate, zero pad
	output logic [imucaf_pkg::M_TDATA_W-1:0]        m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [imucaf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [imucaf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import imucaf_pkg::*;

	localparam logic signed [28:0] LIM29  = 29'(ANGLE_LIM);
	localparam logic signed [29:0] RMAX30 = 30'(RATE_MAX);
	localparam logic signed [29:0] RMIN30 = 30'(RATE_MIN);
	localparam logic signed [31:0] HALF32 = 32'(HALF_TURN);
	localparam logic signed [31:0] FULL32 = 32'(FULL_TURN);
	localparam logic signed [31:0] LIM32  = 32'(ANGLE_LIM);
	localparam logic signed [31:0] RND32  = 32'(1 << (RND_SH - 1));

	state_t state_q, state_d;

	logic signed [15:0] graw_q [3];
	logic signed [15:0] araw_q [3];
	logic        [19:0] dt_q;
	logic signed [26:0] gbias_q [3];
	logic signed [23:0] pbias_q, rbias_q;
	logic signed [27:0] rate_q [3];
	logic signed [27:0] inc_q [3];
	logic signed [26:0] tilt_q [2];
	logic signed [24:0] pitch_q, roll_q, yaw_q;

	logic [2:0]  job_q;
	logic        tsel_q;
	logic [4:0]  cnt_q;

	// divider
	logic signed [49:0]   dvd_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [RCP_W-1:0]     rcp_q;
	logic [2:0]           sh_q;
	logic                 neg_q;
	logic [DSR_W-1:0]     rem_q;
	logic [NUM_W-1:0]     num_q;
	logic [27:0]          quo_q;
	logic [27:0]          nd_q;
	logic [53:0]          prod_q;

	// square root and CORDIC
	logic        [47:0] sv_q, root_q;
	logic signed [26:0] cx_q, cy_q;
	logic signed [31:0] cz_q;

	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic out_free;
	logic s_fire;

	// combinational datapath values
	logic signed [49:0] dvd_c;
	logic [DSR_W-1:0]   dsr_c;
	logic [RCP_W-1:0]   rcp_c;
	logic [2:0]         sh_c;
	logic        [1:0]  axis_c;
	logic signed [49:0] mag50;
	logic        [27:0] nd_c;
	logic [DIG_W-1:0]   qe_c;
	logic        [27:0] qd_c;
	logic        [27:0] rr_c;
	logic               ge;
	logic [DIG_W-1:0]   dig_c;
	logic [DSR_W-1:0]   rnew_c;
	logic signed [28:0] qs;
	logic signed [29:0] rdiff;
	logic signed [15:0] ta, tp, tq;
	logic signed [31:0] tpp, tqq;
	logic        [31:0] tsum;
	logic        [47:0] sbit, srb;
	logic signed [26:0] cxs, cys;
	logic signed [31:0] zr, tz;
	logic signed [31:0] ysum, ywrap;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_fire) state_d = ST_PREP;
			ST_PREP:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_DIVM;
			ST_DIVM:   state_d = ST_DIV;
			ST_DIV:    state_d = (cnt_q == 5'd0) ? ST_WB : ST_DIVM;
			ST_WB: begin
				if (job_q == JOB_INC_Z)
					state_d = ST_TSUM;
				else if (job_q == JOB_MIX_R)
					state_d = ST_YAW;
				else
					state_d = ST_PREP;
			end
			ST_TSUM:   state_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == 5'd0) state_d = ST_CINIT;
			ST_CINIT:  state_d = ST_CORDIC;
			ST_CORDIC: if (cnt_q == 5'(CORDIC_LAST)) state_d = ST_TWB;
			ST_TWB:    state_d = tsel_q ? ST_PREP : ST_TSUM;
			ST_YAW:    state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// divider job operands
	always_comb begin
		axis_c = 2'd0;
		dvd_c  = '0;
		dsr_c  = DSR_W'(RATE_DSR);
		rcp_c  = RCP_W'(RATE_RCP);
		sh_c   = 3'(RATE_SH);
		case (job_q)
			JOB_RATE_X, JOB_RATE_Y, JOB_RATE_Z: begin
				axis_c = job_q[1:0];
				dvd_c  = (50'(graw_q[axis_c]) * 50'sd5) <<< FRAC_BITS;
			end
			JOB_INC_X, JOB_INC_Y, JOB_INC_Z: begin
				axis_c = 2'(job_q - JOB_INC_X);
				dvd_c  = 50'(rate_q[axis_c]) * 50'($signed({1'b0, dt_q}));
				dsr_c  = DSR_W'(TIME_DSR);
				rcp_c  = RCP_W'(TIME_RCP);
				sh_c   = 3'(TIME_SH);
			end
			JOB_MIX_P: begin
				dvd_c = (50'(pitch_q) + 50'(inc_q[1])) * 50'(MIX_OLD) + 50'(tilt_q[0]);
				dsr_c = DSR_W'(MIX_DSR);
				rcp_c = RCP_W'(MIX_RCP);
				sh_c  = 3'(MIX_SH);
			end
			JOB_MIX_R: begin
				dvd_c = (50'(roll_q) + 50'(inc_q[0])) * 50'(MIX_OLD) + 50'(tilt_q[1]);
				dsr_c = DSR_W'(MIX_DSR);
				rcp_c = RCP_W'(MIX_RCP);
				sh_c  = 3'(MIX_SH);
			end
			default: ;
		endcase
	end

	always_comb begin
		mag50  = dvd_q[49] ? -dvd_q : dvd_q;
		// digit dividend stays below divisor * 2^14, so the estimate from the
		// reciprocal is the digit or one less
		nd_c   = {rem_q, num_q[NUM_W-1 -: DIG_W]};
		qe_c   = prod_q[RCP_SH +: DIG_W];
		qd_c   = 28'(qe_c) * 28'(dsr_q);
		rr_c   = nd_q - qd_c;
		ge     = rr_c >= 28'(dsr_q);
		dig_c  = ge ? qe_c + 14'd1 : qe_c;
		rnew_c = ge ? DSR_W'(rr_c - 28'(dsr_q)) : rr_c[DSR_W-1:0];
		qs    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		rdiff = 30'(qs) - 30'(gbias_q[job_q[1:0] == 2'd3 ? 2'd0 : job_q[1:0]]);
		ta    = tsel_q ? araw_q[1] : araw_q[0];
		tp    = tsel_q ? araw_q[0] : araw_q[1];
		tq    = araw_q[2];
		tpp   = 32'(tp) * 32'(tp);
		tqq   = 32'(tq) * 32'(tq);
		tsum  = $unsigned(tpp) + $unsigned(tqq);
		sbit  = 48'd1 << {cnt_q, 1'b0};
		srb   = root_q + sbit;
		cxs   = cx_q >>> cnt_q;
		cys   = cy_q >>> cnt_q;
		zr    = cz_q + RND32;
		tz    = (ta == 16'sd0) ? 32'sd0 : (zr >>> RND_SH);
		ysum  = 32'(yaw_q) + 32'(inc_q[2]);
		if (ysum > HALF32)
			ywrap = ysum - FULL32;
		else if (ysum < -HALF32)
			ywrap = ysum + FULL32;
		else
			ywrap = ysum;
	end

	// control counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q   <= JOB_RATE_X;
			tsel_q  <= 1'b0;
			cnt_q   <= '0;
			pitch_q <= '0;
			roll_q  <= '0;
			yaw_q   <= '0;
			gbias_q <= '{default: '0};
			pbias_q <= '0;
			rbias_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GYRO_BIAS_X:  gbias_q[0] <= $signed(cfg_data);
					REG_GYRO_BIAS_Y:  gbias_q[1] <= $signed(cfg_data);
					REG_GYRO_BIAS_Z:  gbias_q[2] <= $signed(cfg_data);
					REG_ACCEL_BIAS_P: pbias_q    <= $signed(cfg_data[23:0]);
					REG_ACCEL_BIAS_R: rbias_q    <= $signed(cfg_data[23:0]);
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE:   if (s_fire) job_q <= JOB_RATE_X;
				ST_LOAD:   cnt_q <= 5'(DIV_DIGITS - 1);
				ST_DIV:    cnt_q <= cnt_q - 5'd1;
				ST_WB: begin
					if (job_q == JOB_MIX_P) begin
						pitch_q <= (qs > LIM29) ? 25'(LIM29) :
						           (qs < -LIM29) ? 25'(-LIM29) : 25'(qs);
					end
					if (job_q == JOB_MIX_R) begin
						roll_q <= (qs > LIM29) ? 25'(LIM29) :
						          (qs < -LIM29) ? 25'(-LIM29) : 25'(qs);
					end
					if (job_q == JOB_INC_Z)
						tsel_q <= 1'b0;
					else if (job_q != JOB_MIX_R)
						job_q <= job_q + 3'd1;
				end
				ST_TSUM:   cnt_q <= 5'd23;
				ST_SQRT:   cnt_q <= cnt_q - 5'd1;
				ST_CINIT:  cnt_q <= 5'd0;
				ST_CORDIC: cnt_q <= cnt_q + 5'd1;
				ST_TWB: begin
					if (tsel_q)
						job_q <= JOB_MIX_P;
					tsel_q <= 1'b1;
				end
				ST_YAW: begin
					yaw_q <= (ywrap > LIM32) ? 25'(LIM32) :
					         (ywrap < -LIM32) ? 25'(-LIM32) : 25'(ywrap);
				end
				default: ;
			endcase
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					graw_q[0] <= $signed(s_tdata[15:0]);
					graw_q[1] <= $signed(s_tdata[31:16]);
					graw_q[2] <= $signed(s_tdata[47:32]);
					araw_q[0] <= $signed(s_tdata[63:48]);
					araw_q[1] <= $signed(s_tdata[79:64]);
					araw_q[2] <= $signed(s_tdata[95:80]);
					dt_q <= (s_tdata[115:96] > 20'(DT_MAX)) ? 20'(DT_MAX) : s_tdata[115:96];
				end
			end
			ST_PREP: begin
				dvd_q <= dvd_c;
				dsr_q <= dsr_c;
				rcp_q <= rcp_c;
				sh_q  <= sh_c;
			end
			ST_LOAD: begin
				neg_q <= dvd_q[49];
				rem_q <= '0;
				num_q <= NUM_W'(mag50 >> sh_q);
				quo_q <= '0;
			end
			ST_DIVM: begin
				nd_q   <= nd_c;
				prod_q <= 54'(nd_c) * 54'(rcp_q);
			end
			ST_DIV: begin
				rem_q <= rnew_c;
				quo_q <= {quo_q[27-DIG_W:0], dig_c};
				num_q <= num_q << DIG_W;
			end
			ST_WB: begin
				case (job_q)
					JOB_RATE_X, JOB_RATE_Y, JOB_RATE_Z:
						rate_q[job_q[1:0]] <= (rdiff > RMAX30) ? 28'(RMAX30) :
						                      (rdiff < RMIN30) ? 28'(RMIN30) : 28'(rdiff);
					JOB_INC_X:  inc_q[0] <= 28'(qs);
					JOB_INC_Y:  inc_q[1] <= 28'(qs);
					JOB_INC_Z:  inc_q[2] <= 28'(qs);
					default: ;
				endcase
			end
			ST_TSUM: begin
				sv_q   <= {tsum, 16'd0};
				root_q <= '0;
			end
			ST_SQRT: begin
				if (sv_q >= srb) begin
					sv_q   <= sv_q - srb;
					root_q <= (root_q >> 1) + sbit;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			ST_CINIT: begin
				cx_q <= $signed(27'(root_q));
				cy_q <= 27'(ta) <<< 8;
				cz_q <= '0;
			end
			ST_CORDIC: begin
				if (!cy_q[26]) begin
					cx_q <= cx_q + cys;
					cy_q <= cy_q - cxs;
					cz_q <= cz_q + atan_q24(cnt_q);
				end else begin
					cx_q <= cx_q - cys;
					cy_q <= cy_q + cxs;
					cz_q <= cz_q - atan_q24(cnt_q);
				end
			end
			ST_TWB: begin
				if (tsel_q)
					tilt_q[1] <= 27'(tz) - 27'(rbias_q);
				else
					tilt_q[0] <= -27'(tz) - 27'(pbias_q);
			end
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= {1'b0, rate_q[2], rate_q[0], rate_q[1], yaw_q, roll_q, pitch_q};
			end
			default: ;
		endcase
	end

	// divider remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVM |-> rem_q < dsr_q)
		else $error("divider remainder out of range");

	// a sample transfer always starts the first rate job
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_PREP && job_q == JOB_RATE_X)
		else $error("sample transfer did not start the sequence");

	// square root of a 48-bit value fits 25 bits
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CINIT |-> root_q[47:25] == '0)
		else $error("square root too wide");

	// stored pitch and yaw angles stay within the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(pitch_q) <= LIM32 && 32'(pitch_q) >= -LIM32 &&
		32'(yaw_q) <= LIM32 && 32'(yaw_q) >= -LIM32)
		else $error("angle beyond limit");

	// a result is loaded only from the final state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the final state");

endmodule
`default_nettype wire
